// ===== design/dq_pkg.sv =====
// Shared types and codes for the double-ended queue.
package dq_pkg;

    // Request codes carried in the low bits of s_tdata
    typedef enum logic [2:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_WALK_FWD   = 3'd4,
        REQ_WALK_BWD   = 3'd5,
        REQ_COUNT      = 3'd6
    } req_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    localparam int REQ_W   = 3;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;

    // Controller to datapath commands
    typedef struct packed {
        logic    capture;      // latch the accepted request
        logic    push_front;
        logic    push_back;
        logic    pop_front;    // read front entry, advance front
        logic    pop_back;     // retreat back, read that entry
        logic    walk_start;   // set walk pointer and remaining count
        logic    walk_fwd;     // walk direction for walk_start
        logic    walk_step;    // read walk entry, step pointer
        logic    out_load;     // load the output register
        logic    out_use_data; // value from read data, else zero
        logic    out_last;
        status_t out_status;
    } dq_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        req_t req;
        logic full;
        logic empty;
        logic walk_done;
        logic out_free;
    } dq_stat_t;

endpackage

// ===== design/dq_datapath.sv =====
// Datapath of the double-ended queue: ring memory, pointers, output register.
module dq_datapath #(
    parameter int QUEUE_DEPTH = 16,
    localparam int IDX_W = $clog2(QUEUE_DEPTH),
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  dq_pkg::dq_cmd_t         cmd,
    output dq_pkg::dq_stat_t        stat,
    input  logic [dq_pkg::REQ_W-1:0]   in_req,
    input  logic [dq_pkg::VALUE_W-1:0] in_value,
    input  logic                    out_ready,
    output logic                    out_valid,
    output logic [dq_pkg::STAT_W-1:0]  out_status,
    output logic [dq_pkg::VALUE_W-1:0] out_value,
    output logic [CNT_W-1:0]        out_total,
    output logic                    out_last
);
    import dq_pkg::*;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [VALUE_W-1:0] ring_mem [QUEUE_DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    req_t               req_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [IDX_W-1:0]   front_reg, front_next;
    logic [IDX_W-1:0]   back_reg, back_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   walk_idx_reg, walk_idx_next;
    logic [CNT_W-1:0]   walk_left_reg, walk_left_next;
    logic               walk_fwd_reg;

    logic               out_valid_reg;
    logic [STAT_W-1:0]  out_status_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic [CNT_W-1:0]   out_total_reg;
    logic               out_last_reg;

    logic [IDX_W-1:0]   front_inc, front_dec, back_inc, back_dec;
    logic [IDX_W-1:0]   walk_inc, walk_dec;
    logic               wr_en, rd_en;
    logic [IDX_W-1:0]   wr_addr, rd_addr;

    // Ring neighbors with wrap at the depth
    assign front_inc = (front_reg == IDX_LAST) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? IDX_LAST : front_reg - 1'b1;
    assign back_inc  = (back_reg == IDX_LAST) ? '0 : back_reg + 1'b1;
    assign back_dec  = (back_reg == '0) ? IDX_LAST : back_reg - 1'b1;
    assign walk_inc  = (walk_idx_reg == IDX_LAST) ? '0 : walk_idx_reg + 1'b1;
    assign walk_dec  = (walk_idx_reg == '0) ? IDX_LAST : walk_idx_reg - 1'b1;

    // Memory port selection
    assign wr_en   = cmd.push_front | cmd.push_back;
    assign wr_addr = cmd.push_front ? front_dec : back_reg;
    assign rd_en   = cmd.pop_front | cmd.pop_back | cmd.walk_step;
    always_comb begin
        if (cmd.pop_front) begin
            rd_addr = front_reg;
        end else if (cmd.pop_back) begin
            rd_addr = back_dec;
        end else begin
            rd_addr = walk_idx_reg;
        end
    end

    // Ring memory, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[wr_addr] <= val_reg;
        end
        if (rd_en) begin
            rdata_reg <= ring_mem[rd_addr];
        end
    end

    // Pointer and count updates
    always_comb begin
        front_next = front_reg;
        back_next  = back_reg;
        count_next = count_reg;
        if (cmd.push_front) begin
            front_next = front_dec;
            count_next = count_reg + 1'b1;
        end else if (cmd.push_back) begin
            back_next  = back_inc;
            count_next = count_reg + 1'b1;
        end else if (cmd.pop_front) begin
            front_next = front_inc;
            count_next = count_reg - 1'b1;
        end else if (cmd.pop_back) begin
            back_next  = back_dec;
            count_next = count_reg - 1'b1;
        end
    end

    // Walk pointer and remaining entries
    always_comb begin
        walk_idx_next  = walk_idx_reg;
        walk_left_next = walk_left_reg;
        if (cmd.walk_start) begin
            walk_idx_next  = cmd.walk_fwd ? front_reg : back_dec;
            walk_left_next = count_reg;
        end else if (cmd.walk_step) begin
            walk_idx_next  = walk_fwd_reg ? walk_inc : walk_dec;
            walk_left_next = walk_left_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg     <= '0;
            back_reg      <= '0;
            count_reg     <= '0;
            walk_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            front_reg     <= front_next;
            back_reg      <= back_next;
            count_reg     <= count_next;
            walk_left_reg <= walk_left_next;
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        walk_idx_reg <= walk_idx_next;
        if (cmd.walk_start) begin
            walk_fwd_reg <= cmd.walk_fwd;
        end
        if (cmd.capture) begin
            req_reg <= req_t'(in_req);
            val_reg <= in_value;
        end
        if (cmd.out_load) begin
            out_status_reg <= cmd.out_status;
            out_value_reg  <= cmd.out_use_data ? rdata_reg : '0;
            out_total_reg  <= count_reg;
            out_last_reg   <= cmd.out_last;
        end
    end

    assign stat.req       = req_reg;
    assign stat.full      = (count_reg == CNT_FULL);
    assign stat.empty     = (count_reg == '0);
    assign stat.walk_done = (walk_left_reg == '0);
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_value  = out_value_reg;
    assign out_total  = out_total_reg;
    assign out_last   = out_last_reg;

    // Pointers and count stay consistent around the ring
    logic [CNT_W:0] front_plus_count;
    logic [CNT_W:0] back_expect;
    assign front_plus_count = (CNT_W + 1)'(front_reg) + (CNT_W + 1)'(count_reg);
    assign back_expect = (front_plus_count >= (CNT_W + 1)'(QUEUE_DEPTH))
                         ? front_plus_count - (CNT_W + 1)'(QUEUE_DEPTH)
                         : front_plus_count;

    a_ring_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg <= CNT_FULL) && (back_expect == (CNT_W + 1)'(back_reg)))
        else $error("queue pointers and count disagree");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.push_front || cmd.push_back) |-> (count_reg != CNT_FULL))
        else $error("push issued on a full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.pop_front || cmd.pop_back) |-> (count_reg != '0))
        else $error("pop issued on an empty queue");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten before transfer");

endmodule

// ===== design/dq_ctrl.sv =====
// Controller state machine of the double-ended queue.
module dq_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output dq_pkg::dq_cmd_t   cmd,
    input  dq_pkg::dq_stat_t  stat
);
    import dq_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_EXEC     = 5'b00010,
        ST_RESULT   = 5'b00100,
        ST_WALK_RD  = 5'b01000,
        ST_WALK_OUT = 5'b10000
    } state_t;

    state_t  state_reg, state_next;
    status_t res_status_reg, res_status_next;
    logic    res_data_reg, res_data_next;

    assign s_tready = (state_reg == ST_IDLE);

    // Next state and command decode
    always_comb begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        cmd             = '0;
        cmd.out_status  = STAT_OK;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                res_status_next = STAT_OK;
                res_data_next   = 1'b0;
                state_next      = ST_RESULT;
                unique case (stat.req) inside
                    REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                        if (stat.full) begin
                            res_status_next = STAT_FULL;
                        end else begin
                            cmd.push_front = (stat.req == REQ_PUSH_FRONT);
                            cmd.push_back  = (stat.req == REQ_PUSH_BACK);
                        end
                    end
                    REQ_POP_FRONT, REQ_POP_BACK: begin
                        if (stat.empty) begin
                            res_status_next = STAT_EMPTY;
                        end else begin
                            cmd.pop_front = (stat.req == REQ_POP_FRONT);
                            cmd.pop_back  = (stat.req == REQ_POP_BACK);
                            res_data_next = 1'b1;
                        end
                    end
                    REQ_WALK_FWD, REQ_WALK_BWD: begin
                        if (stat.empty) begin
                            res_status_next = STAT_EMPTY;
                        end else begin
                            cmd.walk_start = 1'b1;
                            cmd.walk_fwd   = (stat.req == REQ_WALK_FWD);
                            state_next     = ST_WALK_RD;
                        end
                    end
                    default: begin
                        // count and unused codes report the total only
                        res_status_next = STAT_OK;
                    end
                endcase
            end
            ST_RESULT: begin
                if (stat.out_free) begin
                    cmd.out_load     = 1'b1;
                    cmd.out_use_data = res_data_reg;
                    cmd.out_last     = 1'b1;
                    cmd.out_status   = res_status_reg;
                    state_next       = ST_IDLE;
                end
            end
            ST_WALK_RD: begin
                cmd.walk_step = 1'b1;
                state_next    = ST_WALK_OUT;
            end
            ST_WALK_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load     = 1'b1;
                    cmd.out_use_data = 1'b1;
                    cmd.out_last     = stat.walk_done;
                    state_next       = stat.walk_done ? ST_IDLE : ST_WALK_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            res_status_reg <= STAT_OK;
            res_data_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
            res_data_reg   <= res_data_next;
        end
    end

    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("controller state not one-hot");

    a_capture_then_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> (state_reg == ST_EXEC))
        else $error("accepted request not executed");

    a_step_then_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk_step |=> (state_reg == ST_WALK_OUT))
        else $error("walk read not followed by its output");

endmodule

// ===== design/double_ended_queue.sv =====
// Top level of the bounded double-ended queue.
// A bounded double-ended queue of signed 32-bit values kept in a ring memory of
// QUEUE_DEPTH entries. Each request on the s_ channel pushes at the front or
// back, pops from the front or back, walks all entries in either direction, or
// asks for the count. One request is handled at a time. Push, pop and count
// go through accept, execute and a load of the output register. A walk reads
// each entry and then loads it into the output register before it reads the
// next, set by the one read port of the ring memory and its registered read
// data. A finished result waits in the output register while the next request
// is taken; a load waits while that register still holds an untaken result,
// so m_tready can stall both. A push on a full queue returns status full and
// changes nothing; a pop or a walk on an empty queue returns status empty.
// m_tlast marks the last result of a request. The ring memory holds no reset
// value; only pushed entries are ever read.
module double_ended_queue #(
    parameter int QUEUE_DEPTH = 16,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1),
    localparam int M_TDATA_W = ((dq_pkg::STAT_W + dq_pkg::VALUE_W + CNT_W + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,   // [2:0] req_type, [34:3] push_value
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // status, item_value, entry_total
    output logic                 m_tlast    // last_of_run
);
    import dq_pkg::*;

    dq_cmd_t            cmd;
    dq_stat_t           stat;
    logic [STAT_W-1:0]  out_status;
    logic [VALUE_W-1:0] out_value;
    logic [CNT_W-1:0]   out_total;

    dq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    dq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_req     (s_tdata[REQ_W-1:0]),
        .in_value   (s_tdata[REQ_W+VALUE_W-1:REQ_W]),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_status (out_status),
        .out_value  (out_value),
        .out_total  (out_total),
        .out_last   (m_tlast)
    );

    // Pack result fields, status in the low bits, zero fill to whole bytes
    assign m_tdata = M_TDATA_W'({out_total, out_value, out_status});

endmodule
